>>> hdl/hierarchical_occupancy_bitmap_assert.svh
// ----------------------------------------------------------------------------
// hierarchical_occupancy_bitmap_assert.svh
// Assertion macros for the occupancy bitmap; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_OCCUPANCY_BITMAP_ASSERT_SVH
`define HIERARCHICAL_OCCUPANCY_BITMAP_ASSERT_SVH

`ifndef SYNTH
// holds at every edge outside reset
`define HOB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define HOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HOB_ASSERT_ALWAYS(label, prop, msg)
`define HOB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hdl/hob_pkg.sv
// ----------------------------------------------------------------------------
// hob_pkg
// Shared constants, types and action codes of the occupancy bitmap.
// ----------------------------------------------------------------------------
package hob_pkg;

    localparam int BRANCH    = 64;
    localparam int WORD_BITS = BRANCH;
    localparam int POS_W     = $clog2(BRANCH);
    localparam int IDX_W     = 2 * POS_W;
    localparam int SPAN      = BRANCH * BRANCH;
    localparam int CNT_W     = $clog2(SPAN + 1);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [2:0]           act_t;

    localparam act_t ACT_TEST   = 3'd0;
    localparam act_t ACT_INSERT = 3'd1;
    localparam act_t ACT_ERASE  = 3'd2;
    localparam act_t ACT_NEXT   = 3'd3;
    localparam act_t ACT_PREV   = 3'd4;
    localparam act_t ACT_CLEAR  = 3'd5;

    localparam idx_t IDX_TOP = idx_t'(SPAN - 1);

endpackage

>>> hdl/hob_req_if.sv
// ----------------------------------------------------------------------------
// hob_req_if
// Request channel: one word carries an action, a slot index and a flag.
// ----------------------------------------------------------------------------
interface hob_req_if
    import hob_pkg::*;
();
    logic valid;
    logic ready;
    act_t action;
    idx_t slot_index;
    logic inclusive;

    modport source (output valid, action, slot_index, inclusive, input ready);
    modport sink   (input valid, action, slot_index, inclusive, output ready);
endinterface

>>> hdl/hob_rsp_if.sv
// ----------------------------------------------------------------------------
// hob_rsp_if
// Response channel: hit flag, index and entry count.
// ----------------------------------------------------------------------------
interface hob_rsp_if
    import hob_pkg::*;
();
    logic valid;
    logic ready;
    logic hit;
    idx_t found_index;
    cnt_t entry_count;

    modport source (output valid, hit, found_index, entry_count, input ready);
    modport sink   (input valid, hit, found_index, entry_count, output ready);
endinterface

>>> hdl/hob_leaf_ram.sv
// ----------------------------------------------------------------------------
// hob_leaf_ram
// Leaf word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hob_leaf_ram
    import hob_pkg::*;
(
    input  logic  clk,
    input  logic  wr_en,
    input  pos_t  wr_addr,
    input  word_t wr_data,
    input  logic  rd_en,
    input  pos_t  rd_addr,
    output word_t rd_data
);

    word_t mem [BRANCH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/hob_scan_unit.sv
// ----------------------------------------------------------------------------
// hob_scan_unit
// Shared priority encoder: lowest or highest set bit of one word.
// ----------------------------------------------------------------------------
module hob_scan_unit
    import hob_pkg::*;
(
    input  word_t vec,
    input  logic  from_high,
    output logic  found,
    output pos_t  pos
);

    word_t rev;
    word_t iso;
    pos_t  pos_low;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            rev[i] = from_high ? vec[WORD_BITS-1-i] : vec[i];
        end
        // isolate lowest one, then encode its position
        iso     = rev & (~rev + word_t'(1));
        pos_low = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (iso[i])
            begin
                pos_low = pos_low | pos_t'(i);
            end
        end
        found = |vec;
        pos   = from_high ? (pos_t'(BRANCH - 1) - pos_low) : pos_low;
    end

endmodule

>>> hdl/hierarchical_occupancy_bitmap.sv
// ----------------------------------------------------------------------------
// hierarchical_occupancy_bitmap
// Two-level occupancy bitmap over 4096 slots with membership, insert, erase,
// clear and next/previous search.
// ----------------------------------------------------------------------------
// An item is taken in ST_IDLE and its start word is read into ST_LEAF.
// Test, insert, erase, clear, unused codes and searches that hit in or
// cannot leave the start word finish in ST_LEAF. Other searches scan the
// summary word in ST_SUM and, if it names another leaf word, read that word
// in ST_LEAF2. The leaf store has one read port, so there is one leaf read per
// cycle, and one shared priority encoder serves the start word, the summary
// and the second word. The request side is ready only while no item is in
// flight. A finished result waits in the output register, so the next item
// can be taken while the previous word has not yet been collected. That next
// item then stalls before its result until the output register frees. The
// summary word doubles as the valid bits of the leaf store: a leaf word whose
// summary bit is clear reads as zero, so reset and clear-all take effect at
// once with no sweep.
// ----------------------------------------------------------------------------
`include "hierarchical_occupancy_bitmap_assert.svh"

module hierarchical_occupancy_bitmap
    import hob_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hob_req_if.sink   req,
    hob_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,   // waiting for a request word
        ST_LEAF,   // start word from the store
        ST_SUM,    // summary scan for the next non-empty word
        ST_LEAF2   // second leaf word from the store
    } state_t;

    state_t state_reg, state_next;
    act_t   act_reg, act_next;
    idx_t   slot_reg, slot_next;      // start index for searches
    logic   edge_reg, edge_next;      // exclusive search off the edge
    pos_t   word_k_reg, word_k_next;  // second word picked by the summary
    word_t  summ_reg, summ_next;
    cnt_t   count_reg, count_next;

    logic   out_valid_reg, out_valid_next;
    logic   hit_out_reg, hit_out_next;
    idx_t   idx_out_reg, idx_out_next;
    cnt_t   cnt_out_reg, cnt_out_next;

    // leaf store ports
    logic   ram_wr_en;
    pos_t   ram_wr_addr;
    word_t  ram_wr_data;
    logic   ram_rd_en;
    pos_t   ram_rd_addr;
    word_t  ram_rd_data;

    // shared scan unit
    word_t  scan_vec;
    logic   scan_high;
    logic   scan_found;
    pos_t   scan_pos;

    // decode of the held item
    pos_t   cur_w;
    pos_t   cur_b;
    word_t  cur_bit;
    word_t  leaf_q;
    logic   present;
    logic   is_prev;
    idx_t   fail_idx;
    logic   out_free;
    logic   fin_go;
    word_t  ones;

    hob_leaf_ram u_leaf_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    hob_scan_unit u_scan (
        .vec       (scan_vec),
        .from_high (scan_high),
        .found     (scan_found),
        .pos       (scan_pos)
    );

    assign ones     = '1;
    assign cur_w    = slot_reg[IDX_W-1:POS_W];
    assign cur_b    = slot_reg[POS_W-1:0];
    assign cur_bit  = word_t'(1) << cur_b;
    // words with a clear summary bit were never written since they emptied
    assign leaf_q   = summ_reg[cur_w] ? ram_rd_data : '0;
    assign present  = |(leaf_q & cur_bit);
    assign is_prev  = (act_reg == ACT_PREV);
    assign fail_idx = is_prev ? IDX_TOP : '0;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = hit_out_reg;
    assign rsp.found_index = idx_out_reg;
    assign rsp.entry_count = cnt_out_reg;

    // scan input by phase
    always_comb
    begin
        scan_high = is_prev;
        case (state_reg)
            ST_LEAF:
            begin
                // from b upward, or up to and including b
                scan_vec = is_prev ? (leaf_q & ~((ones << cur_b) << 1))
                                   : (leaf_q & (ones << cur_b));
            end
            ST_SUM:
            begin
                scan_vec = is_prev ? (summ_reg & ~(ones << cur_w))
                                   : (summ_reg & ((ones << cur_w) << 1));
            end
            ST_LEAF2:
            begin
                scan_vec = ram_rd_data;
            end
            default:
            begin
                scan_vec = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        slot_next      = slot_reg;
        edge_next      = edge_reg;
        word_k_next    = word_k_reg;
        summ_next      = summ_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        hit_out_next   = hit_out_reg;
        idx_out_next   = idx_out_reg;
        cnt_out_next   = cnt_out_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cur_w;
        ram_wr_data    = leaf_q | cur_bit;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = req.slot_index[IDX_W-1:POS_W];
        fin_go         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next  = req.action;
                    edge_next = !req.inclusive &&
                                (((req.action == ACT_NEXT) && (req.slot_index == IDX_TOP)) ||
                                 ((req.action == ACT_PREV) && (req.slot_index == '0)));
                    slot_next = req.slot_index;
                    if (!req.inclusive && (req.action == ACT_NEXT))
                    begin
                        slot_next = req.slot_index + idx_t'(1);
                    end
                    else if (!req.inclusive && (req.action == ACT_PREV))
                    begin
                        slot_next = req.slot_index - idx_t'(1);
                    end
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = slot_next[IDX_W-1:POS_W];
                    state_next  = ST_LEAF;
                end
            end

            ST_LEAF:
            begin
                case (act_reg)
                    ACT_TEST, ACT_INSERT, ACT_ERASE:
                    begin
                        hit_out_next = present;
                        idx_out_next = slot_reg;
                        fin_go       = out_free;
                        if (fin_go && present && (act_reg == ACT_ERASE))
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = leaf_q & ~cur_bit;
                            if ((leaf_q & ~cur_bit) == '0)
                            begin
                                summ_next[cur_w] = 1'b0;
                            end
                            count_next = count_reg - cnt_t'(1);
                        end
                        if (fin_go && !present && (act_reg == ACT_INSERT))
                        begin
                            ram_wr_en        = 1'b1;
                            summ_next[cur_w] = 1'b1;
                            count_next       = count_reg + cnt_t'(1);
                        end
                    end
                    ACT_NEXT, ACT_PREV:
                    begin
                        hit_out_next = 1'b0;
                        idx_out_next = fail_idx;
                        if (!edge_reg && scan_found)
                        begin
                            hit_out_next = 1'b1;
                            idx_out_next = {cur_w, scan_pos};
                            fin_go       = out_free;
                        end
                        else if (edge_reg ||
                                 (is_prev && (cur_w == '0)) ||
                                 (!is_prev && (cur_w == pos_t'(BRANCH - 1))))
                        begin
                            fin_go = out_free;
                        end
                        else
                        begin
                            state_next = ST_SUM;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        hit_out_next = 1'b0;
                        idx_out_next = '0;
                        fin_go       = out_free;
                        if (fin_go)
                        begin
                            summ_next  = '0;
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        // unused codes leave the set alone
                        hit_out_next = 1'b0;
                        idx_out_next = '0;
                        fin_go       = out_free;
                    end
                endcase
            end

            ST_SUM:
            begin
                hit_out_next = 1'b0;
                idx_out_next = fail_idx;
                if (scan_found)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = scan_pos;
                    word_k_next = scan_pos;
                    state_next  = ST_LEAF2;
                end
                else
                begin
                    fin_go = out_free;
                end
            end

            ST_LEAF2:
            begin
                // a set summary bit guarantees a non-empty word here
                hit_out_next = 1'b1;
                idx_out_next = {word_k_reg, scan_pos};
                fin_go       = out_free;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin_go)
        begin
            out_valid_next = 1'b1;
            cnt_out_next   = count_next;
            state_next     = ST_IDLE;
        end
        else
        begin
            // result fields only move when a word is finished
            hit_out_next = hit_out_reg;
            idx_out_next = idx_out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_TEST;
            slot_reg      <= '0;
            edge_reg      <= 1'b0;
            word_k_reg    <= '0;
            summ_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_out_reg   <= 1'b0;
            idx_out_reg   <= '0;
            cnt_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            slot_reg      <= slot_next;
            edge_reg      <= edge_next;
            word_k_reg    <= word_k_next;
            summ_reg      <= summ_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            hit_out_reg   <= hit_out_next;
            idx_out_reg   <= idx_out_next;
            cnt_out_reg   <= cnt_out_next;
        end
    end

    // an empty summary means an empty set
    `HOB_ASSERT_ALWAYS(a_empty_count, (summ_reg != '0) || (count_reg == '0), "count without summary")
    // a fresh insert bumps the count by one
    `HOB_ASSERT_NEXT(a_insert_count, (state_reg == ST_LEAF) && fin_go && (act_reg == ACT_INSERT) && !present, count_reg == $past(count_reg) + cnt_t'(1), "insert count")
    // a found search index lies in a non-empty word
    `HOB_ASSERT_NEXT(a_found_word, fin_go && hit_out_next && ((act_reg == ACT_NEXT) || (act_reg == ACT_PREV)), summ_reg[idx_out_reg[IDX_W-1:POS_W]], "found in empty word")

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-level occupancy bitmap. Request words come
// from a pending queue and are driven under several idle/stall mixes. Each
// accepted word updates a local shadow of the bitmap, which predicts the
// response word; the monitor checks every response against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import hob_pkg::*;

    // codes the block must treat as no-ops
    localparam act_t ACT_UNUSED_A = 3'd6;
    localparam act_t ACT_UNUSED_B = 3'd7;

    localparam int HOLD_CYCLES = 60;    // long receiver hold-off
    localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES = 20;    // settle time after the last response

    logic clk;
    logic rst_n;

    hob_req_if req ();
    hob_rsp_if rsp ();

    hierarchical_occupancy_bitmap DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // One pending request word plus the pacing that goes with it. A drain
    // entry carries no request: the sender holds until all responses are in.
    typedef struct {
        act_t action;
        idx_t slot;
        logic incl;
        int   gap_pct;
        int   stall_pct;
        bit   hold;
        bit   drain;
    } op_word_t;

    typedef struct {
        logic hit;
        idx_t index;
        cnt_t count;
    } lookup_rsp_t;

    op_word_t    pending[$];
    lookup_rsp_t expected_rsp[$];   // indexed by acceptance order

    int n_sent;         // request words accepted (driver owned)
    int n_checked;      // response words checked (monitor owned)
    int n_ops;          // request words queued in total
    int errors = 0;
    int stall_pct;      // receiver stall rate of the current phase
    int hold_left;
    logic hold_kick;

    // pacing used by the queue builders
    int  cur_gap;
    int  cur_stall;
    bit  next_hold;

    // shadow of the bitmap
    word_t leaf_mem [BRANCH] = '{default: '0};
    word_t occ_summary = '0;
    cnt_t  occ_count = '0;

    // ------------------------------------------------------------------------
    // Shadow bitmap
    // ------------------------------------------------------------------------
    function automatic int lowest_one(word_t v);
        for (int i = 0; i < WORD_BITS; i++)
            if (v[i])
                return i;
        return -1;
    endfunction

    function automatic int highest_one(word_t v);
        for (int i = WORD_BITS - 1; i >= 0; i--)
            if (v[i])
                return i;
        return -1;
    endfunction

    // First occupied slot at or above start: start word, then the summary
    // picks the next non-empty word and its lowest bit.
    function automatic logic seek_up(idx_t start, output idx_t found);
        int    w;
        int    b;
        int    k;
        word_t cand;
        w = int'(start[IDX_W-1:POS_W]);
        b = int'(start[POS_W-1:0]);
        found = '0;
        cand = leaf_mem[w] & (~word_t'(0) << b);
        if (cand != '0)
        begin
            found = {pos_t'(w), pos_t'(lowest_one(cand))};
            return 1'b1;
        end
        if (w == BRANCH - 1)
            return 1'b0;
        cand = occ_summary & (~word_t'(0) << (w + 1));
        k = lowest_one(cand);
        if (k < 0)
            return 1'b0;
        found = {pos_t'(k), pos_t'(lowest_one(leaf_mem[k]))};
        return 1'b1;
    endfunction

    // Mirror image: last occupied slot at or below start.
    function automatic logic seek_down(idx_t start, output idx_t found);
        int    w;
        int    b;
        int    k;
        word_t cand;
        w = int'(start[IDX_W-1:POS_W]);
        b = int'(start[POS_W-1:0]);
        found = '0;
        cand = leaf_mem[w] & (~word_t'(0) >> (WORD_BITS - 1 - b));
        if (cand != '0)
        begin
            found = {pos_t'(w), pos_t'(highest_one(cand))};
            return 1'b1;
        end
        if (w == 0)
            return 1'b0;
        cand = occ_summary & (~word_t'(0) >> (WORD_BITS - w));
        k = highest_one(cand);
        if (k < 0)
            return 1'b0;
        found = {pos_t'(k), pos_t'(highest_one(leaf_mem[k]))};
        return 1'b1;
    endfunction

    // Applies one request to the shadow and returns the response it implies.
    function automatic lookup_rsp_t predict_lookup(act_t act, idx_t slot, logic incl);
        lookup_rsp_t r;
        int          w;
        int          b;
        logic        present;
        idx_t        at;
        w = int'(slot[IDX_W-1:POS_W]);
        b = int'(slot[POS_W-1:0]);
        present = leaf_mem[w][b];
        r.hit = 1'b0;
        r.index = '0;
        at = '0;
        case (act)
            ACT_TEST:
            begin
                r.hit = present;
                r.index = slot;
            end
            ACT_INSERT:
            begin
                r.hit = present;
                r.index = slot;
                if (!present)
                begin
                    leaf_mem[w][b] = 1'b1;
                    occ_summary[w] = 1'b1;
                    occ_count = occ_count + cnt_t'(1);
                end
            end
            ACT_ERASE:
            begin
                r.hit = present;
                r.index = slot;
                if (present)
                begin
                    leaf_mem[w][b] = 1'b0;
                    if (leaf_mem[w] == '0)
                        occ_summary[w] = 1'b0;
                    occ_count = occ_count - cnt_t'(1);
                end
            end
            ACT_NEXT:
            begin
                // exclusive from the top slot cannot match anything
                if (incl || slot != IDX_TOP)
                    r.hit = seek_up(incl ? slot : idx_t'(slot + 1'b1), at);
                r.index = r.hit ? at : '0;
            end
            ACT_PREV:
            begin
                if (incl || slot != '0)
                    r.hit = seek_down(incl ? slot : idx_t'(slot - 1'b1), at);
                r.index = r.hit ? at : IDX_TOP;
            end
            ACT_CLEAR:
            begin
                leaf_mem = '{default: '0};
                occ_summary = '0;
                occ_count = '0;
            end
            default: ;
        endcase
        r.count = occ_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Queue builders
    // ------------------------------------------------------------------------
    task automatic add_op(act_t act, idx_t slot, logic incl);
        op_word_t op;
        op.action = act;
        op.slot = slot;
        op.incl = incl;
        op.gap_pct = cur_gap;
        op.stall_pct = cur_stall;
        op.hold = next_hold;
        op.drain = 1'b0;
        next_hold = 1'b0;
        pending.push_back(op);
        n_ops++;
    endtask

    task automatic add_drain();
        op_word_t op;
        op = '{action: ACT_TEST, slot: '0, incl: 1'b0, gap_pct: 0, stall_pct: cur_stall,
               hold: 1'b0, drain: 1'b1};
        pending.push_back(op);
    endtask

    // Slots cluster on a few low and high words and on edge bits, so words
    // fill and empty again and searches keep crossing word boundaries.
    task automatic add_random(int count);
        int   r;
        int   w;
        int   b;
        act_t a;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 30)      a = ACT_INSERT;
            else if (r < 50) a = ACT_ERASE;
            else if (r < 60) a = ACT_TEST;
            else if (r < 76) a = ACT_NEXT;
            else if (r < 92) a = ACT_PREV;
            else if (r < 95) a = ACT_CLEAR;
            else if (r < 97) a = ACT_UNUSED_A;
            else             a = ACT_UNUSED_B;
            r = $urandom_range(99);
            if (r < 35)      w = $urandom_range(0, 3);
            else if (r < 70) w = $urandom_range(BRANCH - 4, BRANCH - 1);
            else             w = $urandom_range(0, BRANCH - 1);
            r = $urandom_range(99);
            if (r < 30)      b = $urandom_range(0, 2);
            else if (r < 60) b = $urandom_range(BRANCH - 3, BRANCH - 1);
            else             b = $urandom_range(0, BRANCH - 1);
            add_op(a, {pos_t'(w), pos_t'(b)}, 1'($urandom_range(1)));
        end
    endtask

    task automatic report_field(string what, int want, int got);
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: one request word per handshake. Prediction happens at the
    // accepting edge, so the shadow sees requests in the block's own order.
    // valid is computed in a local and assigned once per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        op_word_t nxt;
        logic     offer;
        logic     kick;
        logic     took;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.action <= ACT_TEST;
            req.slot_index <= '0;
            req.inclusive <= 1'b0;
            n_sent <= 0;
            hold_kick <= 1'b0;
            stall_pct <= 0;
        end
        else
        begin
            took = req.valid && req.ready;
            offer = req.valid && !took;
            kick = 1'b0;
            if (took)
            begin
                expected_rsp.push_back(predict_lookup(req.action, req.slot_index,
                                                      req.inclusive));
                n_sent <= n_sent + 1;
            end
            if (!offer && pending.size() != 0)
            begin
                if (pending[0].drain)
                begin
                    // sender pause: wait for every outstanding response
                    stall_pct <= pending[0].stall_pct;
                    if (!took && n_checked == n_sent)
                        void'(pending.pop_front());
                end
                else if ($urandom_range(99) >= pending[0].gap_pct)
                begin
                    nxt = pending.pop_front();
                    offer = 1'b1;
                    kick = nxt.hold;
                    req.action <= nxt.action;
                    req.slot_index <= nxt.slot;
                    req.inclusive <= nxt.incl;
                    stall_pct <= nxt.stall_pct;
                end
            end
            req.valid <= offer;
            hold_kick <= kick;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each response word against the oldest open prediction
    // and paces ready. A hold kick from the driver closes ready for a long
    // stretch so the block backs up into its request side.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        lookup_rsp_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            n_checked <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (n_checked >= n_sent)
                begin
                    errors++;
                    $display("%0t: unexpected response: expected none, got hit %0b index %0d count %0d",
                             $time, rsp.hit, rsp.found_index, rsp.entry_count);
                end
                else
                begin
                    want = expected_rsp[n_checked];
                    if (rsp.hit !== want.hit)
                        report_field("hit", int'(want.hit), int'(rsp.hit));
                    if (rsp.found_index !== want.index)
                        report_field("found_index", int'(want.index), int'(rsp.found_index));
                    if (rsp.entry_count !== want.count)
                        report_field("entry_count", int'(want.count), int'(rsp.entry_count));
                    n_checked <= n_checked + 1;
                end
            end
            if (hold_kick)
            begin
                hold_left <= HOLD_CYCLES;
                rsp.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no handshake happens for too long.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        n_ops = 0;
        cur_gap = 0;
        cur_stall = 0;
        next_hold = 1'b0;

        // directed: empty-set searches fail with their default indexes
        add_op(ACT_TEST, '0, 1'b0);
        add_op(ACT_NEXT, '0, 1'b1);
        add_op(ACT_PREV, IDX_TOP, 1'b1);
        // corners, a duplicate insert, words far apart
        add_op(ACT_INSERT, '0, 1'b0);
        add_op(ACT_INSERT, IDX_TOP, 1'b1);
        add_op(ACT_INSERT, '0, 1'b0);
        add_op(ACT_INSERT, idx_t'(5 * BRANCH + BRANCH - 1), 1'b0);
        add_op(ACT_INSERT, idx_t'(2000), 1'b0);
        add_op(ACT_TEST, '0, 1'b1);
        add_op(ACT_TEST, idx_t'(1), 1'b0);
        // exclusive searches off either end fail at once
        add_op(ACT_NEXT, IDX_TOP, 1'b0);
        add_op(ACT_PREV, '0, 1'b0);
        // hits in the start word and hits via the summary word
        add_op(ACT_NEXT, '0, 1'b1);
        add_op(ACT_NEXT, '0, 1'b0);
        add_op(ACT_PREV, IDX_TOP, 1'b0);
        add_op(ACT_PREV, IDX_TOP, 1'b1);
        add_op(ACT_NEXT, idx_t'(2000), 1'b0);
        add_op(ACT_PREV, idx_t'(5 * BRANCH + BRANCH - 1), 1'b0);
        add_op(ACT_NEXT, idx_t'(6 * BRANCH), 1'b1);
        // erase of an absent slot, then one that empties its word
        add_op(ACT_ERASE, idx_t'(1), 1'b1);
        add_op(ACT_ERASE, idx_t'(5 * BRANCH + BRANCH - 1), 1'b0);
        add_op(ACT_NEXT, '0, 1'b0);
        // no-op codes, then clear all
        add_op(ACT_UNUSED_A, IDX_TOP, 1'b1);
        add_op(ACT_UNUSED_B, idx_t'(2000), 1'b0);
        add_op(ACT_CLEAR, IDX_TOP, 1'b1);
        add_op(ACT_TEST, IDX_TOP, 1'b0);
        add_drain();

        // free flowing
        add_random(200);

        // long receiver hold-off while the sender keeps offering
        next_hold = 1'b1;
        add_random(12);
        add_drain();

        // sender idle most of the time
        cur_gap = 65;
        cur_stall = 0;
        add_random(200);

        // receiver stalling most of the time
        cur_gap = 0;
        cur_stall = 65;
        add_random(200);
        add_drain();

        // both sides idling now and then
        cur_gap = 15;
        cur_stall = 15;
        add_random(250);

        wait (rst_n === 1'b1);
        while (n_checked != n_ops)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
